/* design/otrl_pkg.sv */
// ----------------------------------------------------------------------------
// otrl_pkg
// Shared constants, register codes and unit request types for the obstacle
// turn rate limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package otrl_pkg;

  localparam int FRAC_BITS = 16;

  localparam int COORD_W = 32;
  localparam int LEN_W   = 31;
  localparam int RATE_W  = 32;

  // serial multiplier: (y - half_length) * (y + half_length)
  localparam int MUL_A_W   = 31;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_A_W);

  // shared restoring divider, one quotient bit per cycle
  localparam int DIV_W      = 64;
  localparam int DIV_CNT_W  = 6;
  localparam int DIV1_STEPS = 62;
  localparam int DIV2_STEPS = FRAC_BITS + 33;

  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_HALF_LENGTH      = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HALF_WIDTH       = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FORWARD_DISTANCE = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPEED            = 8'd3;

  localparam logic [LEN_W-1:0]  HALF_LENGTH_RST      = 31'd19661;
  localparam logic [LEN_W-1:0]  HALF_WIDTH_RST       = 31'd13107;
  localparam logic [LEN_W-1:0]  FORWARD_DISTANCE_RST = 31'd65536;
  localparam logic [RATE_W-1:0] SPEED_RST            = 32'd0;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIV_W-1:0]     divisor;
    logic [DIV_CNT_W-1:0] last_step;
  } div_req_t;

endpackage

`default_nettype wire

/* design/otrl_mul.sv */
// ----------------------------------------------------------------------------
// otrl_mul
// Shift-add multiplier: one bit of the a operand per cycle, unsigned.
// ----------------------------------------------------------------------------
`default_nettype none

module otrl_mul import otrl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mul_req_t           req_i,
  output logic               done_o,
  output logic [MUL_P_W-1:0] prod_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic [MUL_P_W-1:0]   p_q, p_d;
  logic [MUL_B_W-1:0]   b_q, b_d;
  logic [MUL_B_W:0]     sum;

  // upper half accumulates, lower half holds the multiplier bits still unused
  assign sum = {1'b0, p_q[MUL_P_W-1:MUL_A_W]} + (p_q[0] ? {1'b0, b_q} : '0);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    p_d    = p_q;
    b_d    = b_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = MUL_CNT_W'(MUL_A_W - 1);
      p_d    = {{MUL_B_W{1'b0}}, req_i.a};
      b_d    = req_i.b;
    end else if (busy_q) begin
      p_d   = {sum, p_q[MUL_A_W-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

`default_nettype wire

/* design/otrl_div.sv */
// ----------------------------------------------------------------------------
// otrl_div
// Restoring divider, one quotient bit per cycle, unsigned. The dividend is
// given left aligned so that only last_step + 1 steps are needed.
// ----------------------------------------------------------------------------
`default_nettype none

module otrl_div import otrl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     dvd_q, dvd_d;
  logic [DIV_W-1:0]     dvs_q, dvs_d;
  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIV_W-1:0]     rem_t;
  logic                 ge;

  // remainder stays below the divisor, so its top bit is free for the shift
  assign rem_t = {rem_q[DIV_W-2:0], dvd_q[DIV_W-1]};
  assign ge    = (rem_t >= dvs_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.last_step;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? (rem_t - dvs_q) : rem_t;
      quo_d = {quo_q[DIV_W-2:0], ge};
      dvd_d = {dvd_q[DIV_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

/* design/obstacle_turn_rate_limit.sv */
// ----------------------------------------------------------------------------
// obstacle_turn_rate_limit
// Turn rate limit from an obstacle point cloud, one point at a time.
// ----------------------------------------------------------------------------
// Points enter on the s_axis channel (x, y in tdata, tlast on the last point
// of a cloud). One result per cloud leaves on m_axis: omega in tdata, the
// stop flag in tuser. Registers are written on the cfg channel (always
// ready); the user must write them only while no point is in flight;
// the block itself does not enforce this. A point outside the watched
// zone, or any point after a zero radius was seen, passes only through
// the zone check and the finish state. A point inside the zone runs a
// bit-serial multiply (31 steps) and a pass of the shared bit-serial
// divider (62 steps); unless that gives a zero radius, a second divider
// pass (FRAC_BITS + 33 steps) follows.
// s_axis_tready is high only between points. The result of the last point
// sits in an output register, so the next cloud's points are taken while it
// waits; only a further last point waits for the register to drain when
// m_axis_tready stays low.
// Reset clears the per-cloud state, drops any pending result and restores
// the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module obstacle_turn_rate_limit import otrl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // points
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [2*COORD_W-1:0]  s_axis_tdata,   // point_x, point_y
  input  logic                  s_axis_tlast,   // last_point
  // results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [RATE_W-1:0]     m_axis_tdata,   // omega
  output logic                  m_axis_tuser    // stop
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CHK  = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_DIV1 = 4'd3;
  localparam logic [3:0] ST_DSUB = 4'd4;
  localparam logic [3:0] ST_DCHK = 4'd5;
  localparam logic [3:0] ST_DIV2 = 4'd6;
  localparam logic [3:0] ST_SAT  = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  localparam logic [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

  // registers
  logic [LEN_W-1:0]  half_length_q, half_width_q, forward_distance_q;
  logic [RATE_W-1:0] speed_q;

  // control and cloud state
  logic [3:0]        state_q, state_d;
  logic [RATE_W-1:0] left_max_q, left_max_d;
  logic [RATE_W-1:0] right_max_q, right_max_d;
  logic [RATE_W-1:0] latest_rate_q, latest_rate_d;
  logic              stop_latched_q, stop_latched_d;
  logic              out_valid_q, out_valid_d;

  // payload
  logic [COORD_W-1:0] x_q, x_d, y_q, y_d;
  logic               last_q, last_d;
  logic [LEN_W-1:0]   den_q, den_d;
  logic [COORD_W-1:0] hwax_q, hwax_d;
  logic [DIV_W-1:0]   d_q, d_d;
  logic               neg_q, neg_d;
  logic               out_stop_q, out_stop_d;
  logic [RATE_W-1:0]  out_omega_q, out_omega_d;

  // datapath
  logic [COORD_W+1:0] y_ext, hl_ext, lim_ext;
  logic [COORD_W-1:0] ax;
  logic               in_zone, used;
  logic [RATE_W-1:0]  spd_mag;
  logic [DIV_W-1:0]   d_mag, top_mag;
  logic [RATE_W-1:0]  rate;
  logic [RATE_W-1:0]  res_omega;
  logic               res_stop;

  mul_req_t           mul_req;
  div_req_t           div_req;
  logic               mul_done, div_done;
  logic [MUL_P_W-1:0] prod;
  logic [DIV_W-1:0]   quot;

  otrl_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (prod)
  );

  otrl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  // zone test
  assign y_ext   = {{2{y_q[COORD_W-1]}}, y_q};
  assign hl_ext  = {3'b000, half_length_q};
  assign lim_ext = {2'b00, {1'b0, half_length_q} + {1'b0, forward_distance_q}};
  assign ax      = x_q[COORD_W-1] ? (-x_q) : x_q;
  assign in_zone = ($signed(y_ext) > $signed(hl_ext)) && ($signed(y_ext) <= $signed(lim_ext));
  assign used    = in_zone && (ax < {1'b0, half_width_q}) && !stop_latched_q;

  assign d_mag   = d_q[DIV_W-1] ? (-d_q) : d_q;
  assign spd_mag = speed_q[RATE_W-1] ? (-speed_q) : speed_q;
  assign top_mag = DIV_W'(spd_mag) << (FRAC_BITS + 1);

  // saturate the signed quotient to the rate width
  always_comb begin
    if (neg_q) begin
      rate = (quot > DIV_W'(RATE_MIN)) ? RATE_MIN : (-quot[RATE_W-1:0]);
    end else begin
      rate = (quot > DIV_W'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
    end
  end

  assign res_stop  = stop_latched_q || ((left_max_q != '0) && (right_max_q != '0));
  assign res_omega = stop_latched_q ? latest_rate_q :
                     ((left_max_q != '0) ? (-left_max_q) : right_max_q);

  always_comb begin
    state_d        = state_q;
    left_max_d     = left_max_q;
    right_max_d    = right_max_q;
    latest_rate_d  = latest_rate_q;
    stop_latched_d = stop_latched_q;
    out_valid_d    = out_valid_q && !m_axis_tready;
    x_d            = x_q;
    y_d            = y_q;
    last_d         = last_q;
    den_d          = den_q;
    hwax_d         = hwax_q;
    d_d            = d_q;
    neg_d          = neg_q;
    out_stop_d     = out_stop_q;
    out_omega_d    = out_omega_q;

    mul_req.start = 1'b0;
    mul_req.a     = y_q[MUL_A_W-1:0] - half_length_q;
    mul_req.b     = {1'b0, y_q[MUL_A_W-1:0]} + {1'b0, half_length_q};

    div_req.start = 1'b0;
    if (state_q == ST_DCHK) begin
      div_req.dividend  = top_mag << (DIV_W - DIV2_STEPS);
      div_req.divisor   = d_mag;
      div_req.last_step = DIV_CNT_W'(DIV2_STEPS - 1);
    end else begin
      div_req.dividend  = DIV_W'(prod) << (DIV_W - DIV1_STEPS);
      div_req.divisor   = DIV_W'(den_q);
      div_req.last_step = DIV_CNT_W'(DIV1_STEPS - 1);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          x_d     = s_axis_tdata[COORD_W-1:0];
          y_d     = s_axis_tdata[2*COORD_W-1:COORD_W];
          last_d  = s_axis_tlast;
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        den_d  = half_width_q - ax[LEN_W-1:0];
        hwax_d = {1'b0, half_width_q} + ax;
        if (used) begin
          mul_req.start = 1'b1;
          state_d       = ST_MUL;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          div_req.start = 1'b1;
          state_d       = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          state_d = ST_DSUB;
        end
      end
      ST_DSUB: begin
        // twice the radius
        d_d     = quot - DIV_W'(hwax_q);
        state_d = ST_DCHK;
      end
      ST_DCHK: begin
        if (d_q == '0) begin
          stop_latched_d = 1'b1;
          state_d        = ST_FIN;
        end else begin
          neg_d         = speed_q[RATE_W-1] ^ d_q[DIV_W-1];
          div_req.start = 1'b1;
          state_d       = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT: begin
        latest_rate_d = rate;
        if (!x_q[COORD_W-1] && ($signed(rate) > $signed(left_max_q))) begin
          left_max_d = rate;
        end
        if (x_q[COORD_W-1] && ($signed(rate) > $signed(right_max_q))) begin
          right_max_d = rate;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || m_axis_tready) begin
          out_valid_d    = 1'b1;
          out_stop_d     = res_stop;
          out_omega_d    = res_omega;
          left_max_d     = '0;
          right_max_d    = '0;
          latest_rate_d  = '0;
          stop_latched_d = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      left_max_q     <= '0;
      right_max_q    <= '0;
      latest_rate_q  <= '0;
      stop_latched_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      left_max_q     <= left_max_d;
      right_max_q    <= right_max_d;
      latest_rate_q  <= latest_rate_d;
      stop_latched_q <= stop_latched_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    y_q         <= y_d;
    last_q      <= last_d;
    den_q       <= den_d;
    hwax_q      <= hwax_d;
    d_q         <= d_d;
    neg_q       <= neg_d;
    out_stop_q  <= out_stop_d;
    out_omega_q <= out_omega_d;
  end

  // configuration registers, indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_length_q      <= HALF_LENGTH_RST;
      half_width_q       <= HALF_WIDTH_RST;
      forward_distance_q <= FORWARD_DISTANCE_RST;
      speed_q            <= SPEED_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        REG_HALF_LENGTH:      half_length_q      <= cfg_data_i[LEN_W-1:0];
        REG_HALF_WIDTH:       half_width_q       <= cfg_data_i[LEN_W-1:0];
        REG_FORWARD_DISTANCE: forward_distance_q <= cfg_data_i[LEN_W-1:0];
        REG_SPEED:            speed_q            <= cfg_data_i[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_omega_q;
  assign m_axis_tuser  = out_stop_q;

endmodule

`default_nettype wire

/* sim/obstacle_turn_rate_limit_checker.sv */
// ----------------------------------------------------------------------------
// obstacle_turn_rate_limit_checker
// Watches the register, point and result channels of the turn rate limiter.
// Every accepted point goes through a predictor with its own copy of the
// registers and cloud state. Each last point queues the expected stop flag
// and turn rate, and each accepted result is checked against the oldest one.
// ----------------------------------------------------------------------------
module obstacle_turn_rate_limit_checker import otrl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  pt_valid_i,
  input  logic                  pt_ready_i,
  input  logic [2*COORD_W-1:0]  pt_data_i,   // point_x, point_y
  input  logic                  pt_last_i,   // last_point
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  logic [RATE_W-1:0]     res_data_i,  // omega
  input  logic                  res_user_i,  // stop
  output int                    errors_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint RATE_MAX = 64'sd2147483647;
  localparam longint RATE_MIN = -64'sd2147483648;

  typedef struct packed {
    logic              stop;
    logic [RATE_W-1:0] omega;
  } turn_limit_t;

  turn_limit_t limits_due_q[$];

  logic [LEN_W-1:0]  half_length;
  logic [LEN_W-1:0]  half_width;
  logic [LEN_W-1:0]  fwd_distance;
  logic [RATE_W-1:0] speed;

  int   left_peak;
  int   right_peak;
  int   last_rate;
  logic stop_held;

  function automatic void clear_cloud();
    left_peak  = 0;
    right_peak = 0;
    last_rate  = 0;
    stop_held  = 1'b0;
  endfunction

  // fold one point into the cloud state
  function automatic void absorb_point(input int px, input int py);
    longint x, y, hl, hw, ax, quo, dia, rate;
    x  = px;
    y  = py;
    hl = longint'(half_length);
    hw = longint'(half_width);
    ax = (x < 0) ? -x : x;
    if (y <= hl || y > hl + longint'(fwd_distance) || ax >= hw) return;
    // quotient is never negative, so truncation is floor; dia = 2R
    quo = (y * y - hl * hl) / (hw - ax);
    dia = quo - hw - ax;
    if (dia == 0) begin
      stop_held = 1'b1;
      return;
    end
    rate = (longint'(int'(speed)) << (FRAC_BITS + 1)) / dia;
    if (rate > RATE_MAX) rate = RATE_MAX;
    if (rate < RATE_MIN) rate = RATE_MIN;
    last_rate = int'(rate);
    if (x >= 0 && rate > left_peak) left_peak = int'(rate);
    if (x < 0 && rate > right_peak) right_peak = int'(rate);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    turn_limit_t due;
    if (!rst_ni) begin
      half_length  = HALF_LENGTH_RST;
      half_width   = HALF_WIDTH_RST;
      fwd_distance = FORWARD_DISTANCE_RST;
      speed        = SPEED_RST;
      clear_cloud();
      limits_due_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          REG_HALF_LENGTH:      half_length  = cfg_data_i[LEN_W-1:0];
          REG_HALF_WIDTH:       half_width   = cfg_data_i[LEN_W-1:0];
          REG_FORWARD_DISTANCE: fwd_distance = cfg_data_i[LEN_W-1:0];
          REG_SPEED:            speed        = cfg_data_i;
          default: ;
        endcase
      end

      if (res_valid_i && res_ready_i) begin
        if (limits_due_q.size() == 0) begin
          $error("result with no cloud pending: stop %0b omega %0d",
                 res_user_i, $signed(res_data_i));
          errors_o = errors_o + 1;
        end else begin
          due = limits_due_q.pop_front();
          if (res_user_i !== due.stop) begin
            $error("stop mismatch: expected %0b, got %0b", due.stop, res_user_i);
            errors_o = errors_o + 1;
          end
          if (res_data_i !== due.omega) begin
            $error("omega mismatch: expected %0d, got %0d",
                   $signed(due.omega), $signed(res_data_i));
            errors_o = errors_o + 1;
          end
        end
      end

      if (pt_valid_i && pt_ready_i) begin
        if (!stop_held)
          absorb_point(pt_data_i[COORD_W-1:0], pt_data_i[2*COORD_W-1:COORD_W]);
        if (pt_last_i) begin
          due.stop  = stop_held || (left_peak != 0 && right_peak != 0);
          due.omega = stop_held ? last_rate :
                      (left_peak != 0) ? -left_peak : right_peak;
          limits_due_q = {limits_due_q, due};
          clear_cloud();
        end
      end
      pending_o = limits_due_q.size();
    end
  end

endmodule

/* sim/obstacle_turn_rate_limit_test.sv */
// ----------------------------------------------------------------------------
// obstacle_turn_rate_limit_test
// Drives point clouds and register settings into the turn rate limiter.
// A short directed run covers zone borders, zero radius, saturation and the
// field extremes; then random phases, each with its own register setting,
// send mostly in-zone clouds in bursts while the result side stalls at
// random and once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module obstacle_turn_rate_limit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import otrl_pkg::*;

  localparam int     CLK_HALF     = 5;
  localparam int     DRAIN_CYCLES = 2 * (FRAC_BITS + 135);  // slowest point, with margin
  localparam int     CYCLE_LIMIT  = 1_000_000;
  localparam int     ITEM_TARGET  = 450;
  localparam int     PHASE_ITEMS  = 50;
  localparam int     HOLD_CYCLES  = 3000;
  localparam longint COORD_MAX    = 64'sd2147483647;

  localparam logic [LEN_W-1:0]  LEN_MAX       = '1;
  localparam logic [RATE_W-1:0] RATE_MAX_BITS = 32'h7FFF_FFFF;
  localparam logic [RATE_W-1:0] RATE_MIN_BITS = 32'h8000_0000;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [2*COORD_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [RATE_W-1:0]     m_axis_tdata;
  logic                  m_axis_tuser;

  int errors;
  int pending;
  int cycle_cnt  = 0;
  int burst_left = 0;
  int counted    = 0;
  bit hold_armed = 1'b0;
  bit hold_done  = 1'b0;

  // register values in force, used to aim points at the watched zone
  logic [LEN_W-1:0] half_length  = HALF_LENGTH_RST;
  logic [LEN_W-1:0] half_width   = HALF_WIDTH_RST;
  logic [LEN_W-1:0] fwd_distance = FORWARD_DISTANCE_RST;

  obstacle_turn_rate_limit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  obstacle_turn_rate_limit_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .pt_valid_i  (s_axis_tvalid),
    .pt_ready_i  (s_axis_tready),
    .pt_data_i   (s_axis_tdata),
    .pt_last_i   (s_axis_tlast),
    .res_valid_i (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_i  (m_axis_tdata),
    .res_user_i  (m_axis_tuser),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stall patterns, plus one long hold-off
  initial begin : result_stalls
    int       span;
    rx_mode_e mode;
    forever begin
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      span = $urandom_range(200, 20);
      mode = rx_mode_e'($urandom_range(3, 0));
      repeat (span) begin
        case (mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(1, 0));
          RX_SPARSE: m_axis_tready <= ($urandom_range(7, 0) == 0);
          default:   m_axis_tready <= ~m_axis_tready;
        endcase
        @(posedge clk_i);
      end
    end
  end

  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(24, 1);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // wait until every cloud result is out and the block has gone quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_config(input logic [LEN_W-1:0] hl, input logic [LEN_W-1:0] hw,
                              input logic [LEN_W-1:0] fd, input logic [RATE_W-1:0] spd);
    logic [CFG_DATA_W-1:0] junk;
    logic [CFG_ADDR_W-1:0] bad_addr;
    junk = $urandom();
    // unused indexes must leave the registers alone
    if ($urandom_range(2, 0) == 0) begin
      bad_addr = CFG_ADDR_W'($urandom_range(REG_SPEED + 1, 255));
      write_reg(bad_addr, $urandom());
    end
    // bit 31 is dropped by the 31-bit registers
    write_reg(REG_HALF_LENGTH, {junk[31], hl});
    write_reg(REG_HALF_WIDTH, {junk[30], hw});
    write_reg(REG_FORWARD_DISTANCE, {junk[29], fd});
    write_reg(REG_SPEED, spd);
    cfg_valid_i <= 1'b0;
    half_length  = hl;
    half_width   = hw;
    fwd_distance = fd;
  endtask

  task automatic random_config();
    logic [LEN_W-1:0]  hl, hw, fd;
    logic [RATE_W-1:0] spd;
    case ($urandom_range(9, 0))
      0: begin
        hl = $urandom_range(1, 0) ? LEN_MAX : '0;
        hw = $urandom_range(1, 0) ? LEN_MAX : '0;
        fd = $urandom_range(1, 0) ? LEN_MAX : '0;
        case ($urandom_range(2, 0))
          0:       spd = RATE_MIN_BITS;
          1:       spd = RATE_MAX_BITS;
          default: spd = '0;
        endcase
      end
      1, 2: begin
        hl  = LEN_W'($urandom());
        hw  = LEN_W'($urandom());
        fd  = LEN_W'($urandom());
        spd = $urandom();
      end
      default: begin
        hl  = LEN_W'($urandom_range(1 << 18, 0));
        hw  = LEN_W'($urandom_range(1 << 17, 1));
        fd  = LEN_W'($urandom_range(1 << 18, 1));
        spd = ($urandom_range(3, 0) == 0) ? $urandom() : $urandom_range(1 << 19, 0) - (1 << 18);
      end
    endcase
    apply_config(hl, hw, fd, spd);
  endtask

  function automatic logic [COORD_W-1:0] aim_y();
    longint lo, hi;
    lo = longint'(half_length) + 1;
    hi = longint'(half_length) + longint'(fwd_distance);
    if (hi > COORD_MAX) hi = COORD_MAX;
    if (hi < lo) return $urandom();
    case ($urandom_range(7, 0))
      0:       return COORD_W'(lo);
      1:       return COORD_W'(hi);
      default: return $urandom_range(COORD_W'(hi), COORD_W'(lo));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] aim_x();
    logic [COORD_W-1:0] mag;
    if (half_width == 0) return $urandom();
    mag = ($urandom_range(7, 0) == 0) ? half_width - 1 : $urandom_range(half_width - 1, 0);
    return $urandom_range(1, 0) ? -mag : mag;
  endfunction

  // y close to where the radius drops to zero: tiny or zero radius, saturated rates
  task automatic aim_flat(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
    longint ax, yy;
    real    hlr, hwr, axr;
    ax  = (half_width == 0) ? 0 : longint'($urandom_range(half_width - 1, 0));
    hlr = half_length;
    hwr = half_width;
    axr = ax;
    yy  = longint'($ceil($sqrt(hlr * hlr + hwr * hwr - axr * axr)));
    yy  = yy + longint'($urandom_range(2, 0)) - 1;
    if (yy > COORD_MAX) yy = COORD_MAX;
    x = $urandom_range(1, 0) ? COORD_W'(-ax) : COORD_W'(ax);
    y = COORD_W'(yy);
  endtask

  task automatic send_cloud();
    int                 len, pick;
    logic [COORD_W-1:0] x, y;
    len = ($urandom_range(9, 0) == 0) ? $urandom_range(16, 8) : $urandom_range(5, 1);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 60) begin
        x = aim_x();
        y = aim_y();
      end else if (pick < 74) begin
        aim_flat(x, y);
      end else if (pick < 87) begin
        x = $urandom();
        y = $urandom();
      end else begin
        case ($urandom_range(3, 0))
          0: begin
            x = aim_x();
            y = COORD_W'(half_length);
          end
          1: begin
            x = aim_x();
            y = half_length + fwd_distance + 1;
          end
          2: begin
            x = COORD_W'(half_width);
            y = aim_y();
          end
          default: begin
            x = -COORD_W'(half_width);
            y = aim_y();
          end
        endcase
      end
      send_point(x, y, i == len - 1);
      counted++;
    end
  endtask

  initial begin : stimulus
    int phase_start;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values: in zone, zero speed
    send_point(32'd0, 32'd40000, 1'b1);
    settle();

    // 3-4-5 geometry: x = 0, y = 5/4 m gives a zero radius
    apply_config(31'd49152, 31'd65536, 31'd65536, 32'd131072);
    send_point(32'd0, 32'd81920, 1'b0);
    send_point(32'd1234, 32'd90000, 1'b0);          // ignored after the latch
    send_point(-32'sd5, 32'd100000, 1'b1);
    send_point(32'd1000, 32'd100000, 1'b0);
    send_point(32'd0, 32'd81920, 1'b1);             // zero radius on the last point
    send_point(32'd2000, 32'd110000, 1'b0);
    send_point(-32'sd3000, 32'd100000, 1'b0);
    send_point(-32'sd1, 32'd114688, 1'b1);          // both sides, far edge of the zone
    send_point(-32'sd65535, 32'd49153, 1'b1);       // right only, near edges
    send_point(32'd65535, 32'd114688, 1'b1);        // left only
    send_point(32'd65536, 32'd100000, 1'b1);        // |x| == half width
    send_point(-32'sd65536, 32'd100000, 1'b0);
    send_point(32'd0, 32'd49152, 1'b0);             // y == half length
    send_point(32'd0, 32'd114689, 1'b1);            // just past the zone
    send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    settle();

    // widest registers, most negative speed: saturation and a zero radius
    apply_config('0, LEN_MAX, LEN_MAX, RATE_MIN_BITS);
    send_point(32'd0, 32'h7FFF_FFFE, 1'b0);
    send_point(32'hFFFF_FFFF, 32'd1, 1'b1);
    send_point(32'd0, 32'h7FFF_FFFF, 1'b1);

    while (counted < ITEM_TARGET) begin
      settle();
      random_config();
      hold_armed  = 1'b1;
      phase_start = counted;
      while (counted - phase_start < PHASE_ITEMS && counted < ITEM_TARGET) send_cloud();
    end
    settle();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
